// ===== rtl/core/mst_pkg.sv =====
// shared types, kind codes and header decode tables for the msgpack tokenizer
// no dependencies; imported by every module of the block
package mst_pkg;

  localparam int MST_MAX_DEPTH = 16;

  // token kinds
  localparam logic [5:0] K_NIL       = 6'd0;
  localparam logic [5:0] K_BOOL      = 6'd1;
  localparam logic [5:0] K_POSFIX    = 6'd2;
  localparam logic [5:0] K_NEGFIX    = 6'd3;
  localparam logic [5:0] K_UINT8     = 6'd4;
  localparam logic [5:0] K_UINT16    = 6'd5;
  localparam logic [5:0] K_UINT32    = 6'd6;
  localparam logic [5:0] K_UINT64    = 6'd7;
  localparam logic [5:0] K_INT8      = 6'd8;
  localparam logic [5:0] K_INT16     = 6'd9;
  localparam logic [5:0] K_INT32     = 6'd10;
  localparam logic [5:0] K_INT64     = 6'd11;
  localparam logic [5:0] K_FLOAT32   = 6'd12;
  localparam logic [5:0] K_FLOAT64   = 6'd13;
  localparam logic [5:0] K_FIXSTR    = 6'd14;
  localparam logic [5:0] K_STR8      = 6'd15;
  localparam logic [5:0] K_STR16     = 6'd16;
  localparam logic [5:0] K_STR32     = 6'd17;
  localparam logic [5:0] K_BIN8      = 6'd18;
  localparam logic [5:0] K_BIN16     = 6'd19;
  localparam logic [5:0] K_BIN32     = 6'd20;
  localparam logic [5:0] K_FIXARRAY  = 6'd21;
  localparam logic [5:0] K_ARRAY16   = 6'd22;
  localparam logic [5:0] K_ARRAY32   = 6'd23;
  localparam logic [5:0] K_FIXMAP    = 6'd24;
  localparam logic [5:0] K_MAP16     = 6'd25;
  localparam logic [5:0] K_MAP32     = 6'd26;
  localparam logic [5:0] K_FIXEXT1   = 6'd27;
  localparam logic [5:0] K_FIXEXT2   = 6'd28;
  localparam logic [5:0] K_FIXEXT4   = 6'd29;
  localparam logic [5:0] K_FIXEXT8   = 6'd30;
  localparam logic [5:0] K_FIXEXT16  = 6'd31;
  localparam logic [5:0] K_EXT8      = 6'd32;
  localparam logic [5:0] K_EXT16     = 6'd33;
  localparam logic [5:0] K_EXT32     = 6'd34;
  localparam logic [5:0] K_TIMESTAMP = 6'd35;
  localparam logic [5:0] K_ERROR     = 6'd36;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_HDR   = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_TOO_DEEP  = 2'd3;

  // parse phase of the back end
  typedef enum logic [2:0] {
    PH_HEAD,
    PH_LEN,
    PH_EXTTYPE,
    PH_VAL,
    PH_SKIP
  } ph_t;

  // header byte class found by the front end
  typedef enum logic [3:0] {
    HC_POSFIX,
    HC_NEGFIX,
    HC_FIXMAP,
    HC_FIXARRAY,
    HC_FIXSTR,
    HC_NIL,
    HC_BOOL,
    HC_BAD,
    HC_TABLE
  } hclass_t;

  // decode of headers 0xc4..0xdf
  typedef struct packed {
    logic [5:0] kind;
    ph_t        phase;
    logic [4:0] count;
  } tab_t;

  // one classified byte travelling from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] pos;
    hclass_t     hclass;
    tab_t        tab;
  } hdr_t;

  function automatic tab_t hdr_table(input logic [4:0] idx);
    tab_t t;
    unique case (idx)
      5'd0:  t = '{K_BIN8,     PH_LEN,     5'd1};
      5'd1:  t = '{K_BIN16,    PH_LEN,     5'd2};
      5'd2:  t = '{K_BIN32,    PH_LEN,     5'd4};
      5'd3:  t = '{K_EXT8,     PH_LEN,     5'd1};
      5'd4:  t = '{K_EXT16,    PH_LEN,     5'd2};
      5'd5:  t = '{K_EXT32,    PH_LEN,     5'd4};
      5'd6:  t = '{K_FLOAT32,  PH_VAL,     5'd4};
      5'd7:  t = '{K_FLOAT64,  PH_VAL,     5'd8};
      5'd8:  t = '{K_UINT8,    PH_VAL,     5'd1};
      5'd9:  t = '{K_UINT16,   PH_VAL,     5'd2};
      5'd10: t = '{K_UINT32,   PH_VAL,     5'd4};
      5'd11: t = '{K_UINT64,   PH_VAL,     5'd8};
      5'd12: t = '{K_INT8,     PH_VAL,     5'd1};
      5'd13: t = '{K_INT16,    PH_VAL,     5'd2};
      5'd14: t = '{K_INT32,    PH_VAL,     5'd4};
      5'd15: t = '{K_INT64,    PH_VAL,     5'd8};
      5'd16: t = '{K_FIXEXT1,  PH_EXTTYPE, 5'd1};
      5'd17: t = '{K_FIXEXT2,  PH_EXTTYPE, 5'd2};
      5'd18: t = '{K_FIXEXT4,  PH_EXTTYPE, 5'd4};
      5'd19: t = '{K_FIXEXT8,  PH_EXTTYPE, 5'd8};
      5'd20: t = '{K_FIXEXT16, PH_EXTTYPE, 5'd16};
      5'd21: t = '{K_STR8,     PH_LEN,     5'd1};
      5'd22: t = '{K_STR16,    PH_LEN,     5'd2};
      5'd23: t = '{K_STR32,    PH_LEN,     5'd4};
      5'd24: t = '{K_ARRAY16,  PH_LEN,     5'd2};
      5'd25: t = '{K_ARRAY32,  PH_LEN,     5'd4};
      5'd26: t = '{K_MAP16,    PH_LEN,     5'd2};
      5'd27: t = '{K_MAP32,    PH_LEN,     5'd4};
      default: t = '{K_ERROR,  PH_HEAD,    5'd0};
    endcase
    return t;
  endfunction

  // value byte count of a numeric kind
  function automatic logic [3:0] num_bytes(input logic [5:0] k);
    logic [3:0] n;
    case (k)
      K_UINT8, K_INT8:               n = 4'd1;
      K_UINT16, K_INT16:             n = 4'd2;
      K_UINT32, K_INT32, K_FLOAT32:  n = 4'd4;
      default:                       n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/mst_front.sv =====
// front end: byte offset tracking and header byte classification
// depends on mst_pkg
module mst_front import mst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       push,
  output hdr_t       hdr
);

  logic [31:0] byte_position;
  logic [4:0]  tidx;

  // buffer offset, back to zero after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (push) begin
      byte_position <= last_byte ? 32'd0 : byte_position + 32'd1;
    end
  end

  // classify the byte as if it were a header
  always_comb begin
    tidx       = 5'(data_byte - 8'hC4);
    hdr.data   = data_byte;
    hdr.last   = last_byte;
    hdr.pos    = byte_position;
    hdr.tab    = hdr_table(tidx);
    if (data_byte <= 8'h7F)             hdr.hclass = HC_POSFIX;
    else if (data_byte >= 8'hE0)        hdr.hclass = HC_NEGFIX;
    else if (data_byte <= 8'h8F)        hdr.hclass = HC_FIXMAP;
    else if (data_byte <= 8'h9F)        hdr.hclass = HC_FIXARRAY;
    else if (data_byte <= 8'hBF)        hdr.hclass = HC_FIXSTR;
    else if (data_byte == 8'hC0)        hdr.hclass = HC_NIL;
    else if (data_byte == 8'hC1)        hdr.hclass = HC_BAD;
    else if (data_byte <= 8'hC3)        hdr.hclass = HC_BOOL;
    else                                hdr.hclass = HC_TABLE;
  end

endmodule

// ===== rtl/core/mst_fifo.sv =====
// two-entry queue of classified bytes between front and back
// depends on mst_pkg
module mst_fifo import mst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  hdr_t wr_data,
  output logic full,
  input  logic pop,
  output logic rd_valid,
  output hdr_t rd_data
);

  hdr_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/mst_back.sv =====
// back end: parse state machine, nesting stack and token output register
// depends on mst_pkg
module mst_back import mst_pkg::*; #(
  parameter int MAX_DEPTH = MST_MAX_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  hdr_t        q,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  kind,
  output logic [63:0] value,
  output logic [31:0] length,
  output logic [7:0]  ext_code,
  output logic [31:0] payload_offset,
  output logic [4:0]  depth,
  output logic        top_done,
  output logic [1:0]  error_code
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // parse state
  ph_t             phase, phase_next;
  logic [5:0]      hkind, hkind_next;
  logic [63:0]     acc, acc_next;
  logic [4:0]      pend, pend_next;
  logic [31:0]     skip, skip_next;
  logic [31:0]     ns_hold, ns_hold_next;
  logic [LW-1:0]   level, level_next;
  logic [32:0]     cnt [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] one;

  // token under construction
  logic        tv;
  logic [5:0]  tk;
  logic [63:0] tval;
  logic [31:0] tlen;
  logic [7:0]  text;
  logic [31:0] toff;
  logic [LW-1:0] tdepth;
  logic        ttop;
  logic [1:0]  terr;

  // requests raised by the phase logic
  logic        cont_req, pl_req, do_fin, do_push, do_err;
  logic [5:0]  cont_kind, pl_kind;
  logic [31:0] cont_n, pl_len;
  logic [32:0] cont_slots, push_slots;
  logic [7:0]  pl_ext;
  logic [1:0]  err_code;

  // stack pop search
  logic          fin_found;
  logic [IW-1:0] fin_t;
  logic [LW-1:0] fin_level;
  logic [32:0]   fin_cnt;

  logic [7:0]  b;
  logic [31:0] p;
  logic [31:0] len_w;
  logic [3:0]  nb;
  logic [4:0]  tsn;
  logic        ts;
  logic [7:0]  tdepth8;

  assign pop = q_valid && (!out_valid || !out_stall);
  assign b   = q.data;
  assign p   = q.pos;

  // highest open level whose count does not run out on this element
  always_comb begin
    fin_found = 1'b0;
    fin_t     = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((LW'(i) < level) && !one[i]) begin
        fin_found = 1'b1;
        fin_t     = IW'(i);
      end
    end
    fin_cnt   = cnt[fin_t];
    fin_level = fin_found ? LW'(fin_t) + LW'(1) : '0;
  end

  // phase logic, token build and next state
  always_comb begin
    phase_next   = phase;
    hkind_next   = hkind;
    acc_next     = acc;
    pend_next    = pend;
    skip_next    = skip;
    ns_hold_next = ns_hold;
    tv = 1'b0; tk = K_NIL; tval = '0; tlen = '0; text = '0; toff = '0;
    tdepth = level; terr = ERR_NONE;
    cont_req = 1'b0; cont_kind = K_NIL; cont_n = '0; cont_slots = '0;
    pl_req = 1'b0; pl_kind = K_NIL; pl_len = '0; pl_ext = '0;
    do_fin = 1'b0; do_push = 1'b0; push_slots = '0;
    do_err = 1'b0; err_code = ERR_NONE;
    len_w = '0; nb = '0; tsn = '0; ts = 1'b0;

    unique case (phase)
      PH_SKIP: begin
        skip_next = skip - 32'd1;
        if (skip_next == 32'd0) phase_next = PH_HEAD;
      end
      PH_LEN: begin
        acc_next  = {32'd0, acc[23:0], b};
        pend_next = pend - 5'd1;
        if (pend_next == 5'd0) begin
          len_w      = acc_next[31:0];
          acc_next   = '0;
          phase_next = PH_HEAD;
          if (hkind == K_EXT8 || hkind == K_EXT16 || hkind == K_EXT32) begin
            skip_next  = len_w;
            phase_next = PH_EXTTYPE;
          end else if (hkind == K_ARRAY16 || hkind == K_ARRAY32) begin
            cont_req = 1'b1; cont_kind = hkind; cont_n = len_w;
            cont_slots = {1'b0, len_w};
          end else if (hkind == K_MAP16 || hkind == K_MAP32) begin
            cont_req = 1'b1; cont_kind = hkind; cont_n = len_w;
            cont_slots = {len_w, 1'b0};
          end else begin
            pl_req = 1'b1; pl_kind = hkind; pl_len = len_w;
          end
        end
      end
      PH_EXTTYPE: begin
        if (b == 8'hFF) begin
          if (hkind == K_FIXEXT4 && skip == 32'd4) ts = 1'b1;
          if (hkind == K_FIXEXT8 && skip == 32'd8) ts = 1'b1;
          if (hkind == K_EXT8 && (skip == 32'd4 || skip == 32'd8 || skip == 32'd12))
            ts = 1'b1;
        end
        if (ts) begin
          hkind_next   = K_TIMESTAMP;
          acc_next     = '0;
          ns_hold_next = '0;
          pend_next    = skip[4:0];
          phase_next   = PH_VAL;
        end else begin
          pl_req = 1'b1; pl_kind = hkind; pl_len = skip; pl_ext = b;
        end
      end
      PH_VAL: begin
        if (hkind == K_TIMESTAMP && skip == 32'd12 && pend > 5'd8)
          ns_hold_next = {ns_hold[23:0], b};
        else
          acc_next = {acc[55:0], b};
        pend_next = pend - 5'd1;
        if (pend_next == 5'd0) begin
          phase_next = PH_HEAD;
          tv = 1'b1;
          tk = hkind;
          if (hkind == K_TIMESTAMP) begin
            tsn  = skip[4:0];
            tval = acc_next;
            text = 8'hFF;
            if (tsn == 5'd8) begin
              tlen = 32'(acc_next[63:34]);
              tval = {30'd0, acc_next[33:0]};
            end else if (tsn == 5'd12) begin
              tlen = ns_hold;
            end
            toff = p + 32'd1 - 32'(tsn);
          end else begin
            nb = num_bytes(hkind);
            case (hkind)
              K_INT8:  tval = {{56{acc_next[7]}}, acc_next[7:0]};
              K_INT16: tval = {{48{acc_next[15]}}, acc_next[15:0]};
              K_INT32: tval = {{32{acc_next[31]}}, acc_next[31:0]};
              default: tval = acc_next;
            endcase
            toff = p + 32'd1 - 32'(nb);
          end
          skip_next = '0;
          acc_next  = '0;
          do_fin    = 1'b1;
        end
      end
      default: begin
        unique case (q.hclass)
          HC_POSFIX: begin
            tv = 1'b1; tk = K_POSFIX; tval = {56'd0, b}; do_fin = 1'b1;
          end
          HC_NEGFIX: begin
            tv = 1'b1; tk = K_NEGFIX; tval = {56'hFF_FFFF_FFFF_FFFF, b};
            do_fin = 1'b1;
          end
          HC_FIXMAP: begin
            cont_req = 1'b1; cont_kind = K_FIXMAP; cont_n = {28'd0, b[3:0]};
            cont_slots = {28'd0, b[3:0], 1'b0};
          end
          HC_FIXARRAY: begin
            cont_req = 1'b1; cont_kind = K_FIXARRAY; cont_n = {28'd0, b[3:0]};
            cont_slots = {29'd0, b[3:0]};
          end
          HC_FIXSTR: begin
            pl_req = 1'b1; pl_kind = K_FIXSTR; pl_len = {27'd0, b[4:0]};
          end
          HC_NIL: begin
            tv = 1'b1; tk = K_NIL; do_fin = 1'b1;
          end
          HC_BOOL: begin
            tv = 1'b1; tk = K_BOOL; tval = {63'd0, b[0]}; do_fin = 1'b1;
          end
          HC_BAD: begin
            do_err = 1'b1; err_code = ERR_BAD_HDR;
          end
          default: begin
            hkind_next   = q.tab.kind;
            phase_next   = q.tab.phase;
            acc_next     = '0;
            ns_hold_next = '0;
            if (q.tab.phase == PH_EXTTYPE) begin
              skip_next = {27'd0, q.tab.count};
              pend_next = '0;
            end else begin
              pend_next = q.tab.count;
              skip_next = '0;
            end
          end
        endcase
      end
    endcase

    // container header: empty, too deep, or opens a level
    if (cont_req) begin
      if (cont_slots == 33'd0) begin
        tv = 1'b1; tk = cont_kind; tlen = cont_n; toff = p + 32'd1; do_fin = 1'b1;
      end else if (level >= LW'(MAX_DEPTH)) begin
        do_err = 1'b1; err_code = ERR_TOO_DEEP;
      end else begin
        tv = 1'b1; tk = cont_kind; tlen = cont_n; toff = p + 32'd1;
        do_push = 1'b1; push_slots = cont_slots;
      end
    end

    // str, bin and ext: token now, payload skipped
    if (pl_req) begin
      tv = 1'b1; tk = pl_kind; tlen = pl_len; text = pl_ext; toff = p + 32'd1;
      skip_next  = pl_len;
      phase_next = (pl_len != 32'd0) ? PH_SKIP : PH_HEAD;
      do_fin     = 1'b1;
    end

    // stack level after this byte
    if (do_err)       level_next = '0;
    else if (do_push) level_next = level + LW'(1);
    else if (do_fin)  level_next = fin_level;
    else              level_next = level;
    ttop = do_fin && !fin_found;

    if (do_err) begin
      tv = 1'b1; tk = K_ERROR; tval = '0; tlen = '0; text = '0; toff = p;
      ttop = 1'b0; terr = err_code;
      phase_next = PH_HEAD; hkind_next = '0; acc_next = '0; pend_next = '0;
      skip_next = '0; ns_hold_next = '0;
    end

    // end of buffer: anything still open is a truncation
    if (q.last) begin
      if (!do_err && (phase_next != PH_HEAD || level_next != '0)) begin
        tv = 1'b1; tk = K_ERROR; tval = '0; tlen = '0; text = '0; toff = p;
        tdepth = level_next; ttop = 1'b0; terr = ERR_TRUNCATED;
      end
      phase_next = PH_HEAD; hkind_next = '0; acc_next = '0; pend_next = '0;
      skip_next = '0; ns_hold_next = '0; level_next = '0;
    end
    tdepth8 = 8'(tdepth);
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HEAD;
      hkind   <= '0;
      acc     <= '0;
      pend    <= '0;
      skip    <= '0;
      ns_hold <= '0;
      level   <= '0;
    end else if (pop) begin
      phase   <= phase_next;
      hkind   <= hkind_next;
      acc     <= acc_next;
      pend    <= pend_next;
      skip    <= skip_next;
      ns_hold <= ns_hold_next;
      level   <= level_next;
    end
  end

  // nesting stack: push a new level or count down the surviving one
  always_ff @(posedge clk) begin
    if (pop && do_push) begin
      cnt[IW'(level)] <= push_slots;
      one[IW'(level)] <= (push_slots == 33'd1);
    end else if (pop && do_fin && fin_found) begin
      cnt[fin_t] <= fin_cnt - 33'd1;
      one[fin_t] <= (fin_cnt == 33'd2);
    end
  end

  // output register, loaded while the previous token is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && tv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tv) begin
      kind           <= tk;
      value          <= tval;
      length         <= tlen;
      ext_code       <= text;
      payload_offset <= toff;
      depth          <= tdepth8[4:0];
      top_done       <= ttop;
      error_code     <= terr;
    end
  end

  // stack never grows past its limit
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LW'(MAX_DEPTH))
    else $error("nesting level beyond limit");

  // an error token leaves the parser at a top-level header
  a_err_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && tv && tk == K_ERROR) |=> (level == '0 && phase == PH_HEAD))
    else $error("parse state not cleared after error");

  // skipping always has bytes left to skip
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (skip != 32'd0))
    else $error("skip phase with empty count");

  // error tokens never close a top-level object
  a_err_no_top: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == K_ERROR) |-> (!top_done && error_code != ERR_NONE))
    else $error("error token with top_done or no code");

endmodule

// ===== rtl/core/msgpack_stream_tokenizer.sv =====
// top level of the msgpack stream tokenizer: front classifier, queue, back parser
// depends on mst_pkg, mst_front, mst_fifo, mst_back
// Takes a MessagePack buffer one byte per transaction and returns one token per
// object once its header, length, type and value bytes are in; str, bin and ext
// payload bytes are skipped without a token. A byte is taken every cycle
// while the queue is not full: the front end tracks the buffer offset and
// classifies the header byte, a two-entry queue hands it to the back end, whose
// parse state and nesting stack of MAX_DEPTH element counts update once per
// byte, and a registered output holds the token; while a token waits the queue
// takes up to two more bytes before the input stalls. Each byte is held in the
// queue, and its token in the output register. Raising last_byte ends the
// buffer; an object or container still open then gives a truncation error.
module msgpack_stream_tokenizer import mst_pkg::*; #(
  parameter int MAX_DEPTH = MST_MAX_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  kind,
  output logic [63:0] value,
  output logic [31:0] length,
  output logic [7:0]  ext_code,
  output logic [31:0] payload_offset,
  output logic [4:0]  depth,
  output logic        top_done,
  output logic [1:0]  error_code
);

  hdr_t hdr_in;
  hdr_t hdr_q;
  logic full;
  logic push;
  logic q_valid;
  logic pop;

  assign in_stall = full;
  assign push     = in_valid && !full;

  // header classification and offset counter
  mst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .hdr       (hdr_in)
  );

  // decoupling queue
  mst_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (hdr_in),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_data  (hdr_q)
  );

  // parser, stack and token register
  mst_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q              (hdr_q),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .value          (value),
    .length         (length),
    .ext_code       (ext_code),
    .payload_offset (payload_offset),
    .depth          (depth),
    .top_done       (top_done),
    .error_code     (error_code)
  );

endmodule

// ===== sim/mst_checker.sv =====
// token checker for the msgpack stream tokenizer: predicts tokens from accepted bytes
// depends on mst_pkg; watches both channels of the block and counts mismatches
module mst_checker import mst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  kind,
  input  logic [63:0] value,
  input  logic [31:0] length,
  input  logic [7:0]  ext_code,
  input  logic [31:0] payload_offset,
  input  logic [4:0]  depth,
  input  logic        top_done,
  input  logic [1:0]  error_code,
  output int          fail_count,
  output int          pending_tokens,
  output int          token_count,
  output int          error_tokens
);

  typedef struct packed {
    logic [5:0]  kind;
    logic [63:0] value;
    logic [31:0] length;
    logic [7:0]  ext_code;
    logic [31:0] offset;
    logic [4:0]  depth;
    logic        top_done;
    logic [1:0]  err;
  } token_t;

  token_t      token_queue[$];

  // predictor state
  logic [31:0] pos_q;
  logic [5:0]  hkind_q;
  logic [63:0] acc_q;
  logic [4:0]  need_q;
  logic [31:0] skip_q;
  logic [32:0] counts_q[MST_MAX_DEPTH];
  logic [4:0]  level_q;
  ph_t         ph_q;
  logic [31:0] ns_q;
  logic        have_tok;
  token_t      tok;

  assign pending_tokens = token_queue.size();

  task automatic clear_parse();
    hkind_q = '0; acc_q = '0; need_q = '0; skip_q = '0;
    level_q = '0; ph_q = PH_HEAD; ns_q = '0;
  endtask

  task automatic emit(input logic [5:0] k, input logic [63:0] v, input logic [31:0] n,
                      input logic [7:0] x, input logic [31:0] off, input logic [1:0] e);
    have_tok = 1'b1;
    tok = '{k, v, n, x, off, level_q, 1'b0, e};
  endtask

  task automatic raise_error(input logic [1:0] code, input logic [31:0] p);
    emit(K_ERROR, '0, '0, '0, p, code);
    clear_parse();
  endtask

  // one element done: pop every level that ran out
  function automatic logic close_element();
    logic [4:0] t;
    while (level_q > 0) begin
      t = level_q - 5'd1;
      counts_q[t[3:0]] = counts_q[t[3:0]] - 33'd1;
      if (counts_q[t[3:0]] != 0) return 1'b0;
      level_q = t;
    end
    return 1'b1;
  endfunction

  task automatic open_container(input logic [5:0] k, input logic [31:0] n,
                                input logic [32:0] slots, input logic [31:0] p);
    if (slots == 0) begin
      emit(k, '0, n, '0, p + 1, ERR_NONE);
      tok.top_done = close_element();
    end else if (level_q >= MST_MAX_DEPTH) begin
      raise_error(ERR_TOO_DEEP, p);
    end else begin
      emit(k, '0, n, '0, p + 1, ERR_NONE);
      counts_q[level_q[3:0]] = slots;
      level_q++;
    end
  endtask

  task automatic payload_token(input logic [5:0] k, input logic [31:0] n,
                               input logic [7:0] x, input logic [31:0] p);
    emit(k, '0, n, x, p + 1, ERR_NONE);
    skip_q = n;
    ph_q = (n != 0) ? PH_SKIP : PH_HEAD;
    tok.top_done = close_element();
  endtask

  task automatic take_header(input logic [7:0] b, input logic [31:0] p);
    logic [5:0] tk;
    logic [2:0] tp;
    logic [4:0] tc;
    if (b <= 8'h7f) begin
      emit(K_POSFIX, {56'd0, b}, '0, '0, '0, ERR_NONE);
      tok.top_done = close_element();
    end else if (b >= 8'he0) begin
      emit(K_NEGFIX, {56'hffffffffffffff, b}, '0, '0, '0, ERR_NONE);
      tok.top_done = close_element();
    end else if (b <= 8'h8f) begin
      open_container(K_FIXMAP, {28'd0, b[3:0]}, {28'd0, b[3:0], 1'b0}, p);
    end else if (b <= 8'h9f) begin
      open_container(K_FIXARRAY, {28'd0, b[3:0]}, {29'd0, b[3:0]}, p);
    end else if (b[7:5] == 3'b101) begin
      payload_token(K_FIXSTR, {27'd0, b[4:0]}, '0, p);
    end else if (b == 8'hc0) begin
      emit(K_NIL, '0, '0, '0, '0, ERR_NONE);
      tok.top_done = close_element();
    end else if (b == 8'hc2 || b == 8'hc3) begin
      emit(K_BOOL, {63'd0, b[0]}, '0, '0, '0, ERR_NONE);
      tok.top_done = close_element();
    end else if (b == 8'hc1) begin
      raise_error(ERR_BAD_HDR, p);
    end else begin
      // own decode of the fixed-width header range
      tc = 5'd0;
      case (b)
        8'hc4: begin tk = K_BIN8;  tp = PH_LEN; tc = 5'd1; end
        8'hc5: begin tk = K_BIN16; tp = PH_LEN; tc = 5'd2; end
        8'hc6: begin tk = K_BIN32; tp = PH_LEN; tc = 5'd4; end
        8'hc7: begin tk = K_EXT8;  tp = PH_LEN; tc = 5'd1; end
        8'hc8: begin tk = K_EXT16; tp = PH_LEN; tc = 5'd2; end
        8'hc9: begin tk = K_EXT32; tp = PH_LEN; tc = 5'd4; end
        8'hca: begin tk = K_FLOAT32; tp = PH_VAL; tc = 5'd4; end
        8'hcb: begin tk = K_FLOAT64; tp = PH_VAL; tc = 5'd8; end
        8'hcc: begin tk = K_UINT8;  tp = PH_VAL; tc = 5'd1; end
        8'hcd: begin tk = K_UINT16; tp = PH_VAL; tc = 5'd2; end
        8'hce: begin tk = K_UINT32; tp = PH_VAL; tc = 5'd4; end
        8'hcf: begin tk = K_UINT64; tp = PH_VAL; tc = 5'd8; end
        8'hd0: begin tk = K_INT8;  tp = PH_VAL; tc = 5'd1; end
        8'hd1: begin tk = K_INT16; tp = PH_VAL; tc = 5'd2; end
        8'hd2: begin tk = K_INT32; tp = PH_VAL; tc = 5'd4; end
        8'hd3: begin tk = K_INT64; tp = PH_VAL; tc = 5'd8; end
        8'hd4: begin tk = K_FIXEXT1;  tp = PH_EXTTYPE; tc = 5'd1; end
        8'hd5: begin tk = K_FIXEXT2;  tp = PH_EXTTYPE; tc = 5'd2; end
        8'hd6: begin tk = K_FIXEXT4;  tp = PH_EXTTYPE; tc = 5'd4; end
        8'hd7: begin tk = K_FIXEXT8;  tp = PH_EXTTYPE; tc = 5'd8; end
        8'hd8: begin tk = K_FIXEXT16; tp = PH_EXTTYPE; tc = 5'd16; end
        8'hd9: begin tk = K_STR8;  tp = PH_LEN; tc = 5'd1; end
        8'hda: begin tk = K_STR16; tp = PH_LEN; tc = 5'd2; end
        8'hdb: begin tk = K_STR32; tp = PH_LEN; tc = 5'd4; end
        8'hdc: begin tk = K_ARRAY16; tp = PH_LEN; tc = 5'd2; end
        8'hdd: begin tk = K_ARRAY32; tp = PH_LEN; tc = 5'd4; end
        8'hde: begin tk = K_MAP16; tp = PH_LEN; tc = 5'd2; end
        default: begin tk = K_MAP32; tp = PH_LEN; tc = 5'd4; end
      endcase
      hkind_q = tk;
      ph_q = ph_t'(tp);
      acc_q = '0;
      ns_q = '0;
      if (ph_q == PH_EXTTYPE) begin
        skip_q = {27'd0, tc}; need_q = '0;
      end else begin
        need_q = tc; skip_q = '0;
      end
    end
  endtask

  task automatic take_length(input logic [7:0] b, input logic [31:0] p);
    logic [31:0] n;
    acc_q = {32'd0, acc_q[23:0], b};
    need_q--;
    if (need_q == 0) begin
      n = acc_q[31:0];
      acc_q = '0;
      ph_q = PH_HEAD;
      if (hkind_q >= K_EXT8 && hkind_q <= K_EXT32) begin
        skip_q = n; ph_q = PH_EXTTYPE;
      end else if (hkind_q == K_ARRAY16 || hkind_q == K_ARRAY32)
        open_container(hkind_q, n, {1'b0, n}, p);
      else if (hkind_q == K_MAP16 || hkind_q == K_MAP32)
        open_container(hkind_q, n, {n, 1'b0}, p);
      else
        payload_token(hkind_q, n, '0, p);
    end
  endtask

  task automatic take_ext_type(input logic [7:0] b, input logic [31:0] p);
    logic is_ts;
    is_ts = (b == 8'hff) &&
            ((hkind_q == K_FIXEXT4 && skip_q == 4) ||
             (hkind_q == K_FIXEXT8 && skip_q == 8) ||
             (hkind_q == K_EXT8 && (skip_q == 4 || skip_q == 8 || skip_q == 12)));
    if (is_ts) begin
      hkind_q = K_TIMESTAMP; acc_q = '0; ns_q = '0;
      need_q = skip_q[4:0]; ph_q = PH_VAL;
    end else
      payload_token(hkind_q, skip_q, b, p);
  endtask

  task automatic take_value(input logic [7:0] b, input logic [31:0] p);
    logic [31:0] nb;
    logic [63:0] v;
    logic [31:0] ns;
    if (hkind_q == K_TIMESTAMP && skip_q == 12 && need_q > 8)
      ns_q = {ns_q[23:0], b};
    else
      acc_q = {acc_q[55:0], b};
    need_q--;
    if (need_q == 0) begin
      ph_q = PH_HEAD;
      v = acc_q;
      if (hkind_q == K_TIMESTAMP) begin
        nb = {27'd0, skip_q[4:0]};
        ns = '0;
        if (nb == 8) begin
          ns = {2'd0, v[63:34]}; v = {30'd0, v[33:0]};
        end else if (nb == 12)
          ns = ns_q;
        emit(K_TIMESTAMP, v, ns, 8'hff, p + 1 - nb, ERR_NONE);
      end else begin
        case (hkind_q)
          K_UINT8, K_INT8: nb = 1;
          K_UINT16, K_INT16: nb = 2;
          K_UINT32, K_INT32, K_FLOAT32: nb = 4;
          default: nb = 8;
        endcase
        if (hkind_q == K_INT8 && v[7]) v[63:8] = '1;
        if (hkind_q == K_INT16 && v[15]) v[63:16] = '1;
        if (hkind_q == K_INT32 && v[31]) v[63:32] = '1;
        emit(hkind_q, v, '0, '0, p + 1 - nb, ERR_NONE);
      end
      skip_q = '0;
      acc_q = '0;
      tok.top_done = close_element();
    end
  endtask

  // predict the token of one accepted byte
  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [31:0] p;
    p = pos_q;
    have_tok = 1'b0;
    case (ph_q)
      PH_SKIP: begin
        skip_q--;
        if (skip_q == 0) ph_q = PH_HEAD;
      end
      PH_LEN:     take_length(b, p);
      PH_EXTTYPE: take_ext_type(b, p);
      PH_VAL:     take_value(b, p);
      default:    take_header(b, p);
    endcase
    if (fin) begin
      if (!(have_tok && tok.kind == K_ERROR) && (ph_q != PH_HEAD || level_q != 0))
        raise_error(ERR_TRUNCATED, p);
      clear_parse();
      pos_q = '0;
    end else
      pos_q = p + 1;
    if (have_tok) token_queue.push_back(tok);
  endtask

  // watch both channels
  always @(posedge clk) begin
    token_t exp_tok;
    token_t got;
    if (rst) begin
      pos_q = '0;
      clear_parse();
      token_queue.delete();
      fail_count <= 0;
      token_count <= 0;
      error_tokens <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{kind, value, length, ext_code, payload_offset, depth, top_done, error_code};
        token_count <= token_count + 1;
        if (kind == K_ERROR) error_tokens <= error_tokens + 1;
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token kind %0d", $time, kind);
          fail_count <= fail_count + 1;
        end else begin
          exp_tok = token_queue.pop_front();
          if (got !== exp_tok) begin
            $display("%0t: token mismatch expected k=%0d v=%h l=%h x=%h o=%h d=%0d t=%0d e=%0d",
                     $time, exp_tok.kind, exp_tok.value, exp_tok.length, exp_tok.ext_code,
                     exp_tok.offset, exp_tok.depth, exp_tok.top_done, exp_tok.err);
            $display("%0t:            actual k=%0d v=%h l=%h x=%h o=%h d=%0d t=%0d e=%0d",
                     $time, got.kind, got.value, got.length, got.ext_code,
                     got.offset, got.depth, got.top_done, got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict_byte(data_byte, last_byte);
    end
  end

endmodule

// ===== sim/tb.sv =====
// stimulus and verdict for the msgpack stream tokenizer
// depends on mst_pkg, msgpack_stream_tokenizer and mst_checker
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  kind;
  logic [63:0] value;
  logic [31:0] length;
  logic [7:0]  ext_code;
  logic [31:0] payload_offset;
  logic [4:0]  depth;
  logic        top_done;
  logic [1:0]  error_code;
  int          fail_count, pending_tokens, token_count, error_tokens;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_request = 0;
  int          hold_served = 0;
  int          hold_cycles = 0;
  int          idle_run = 0;
  int          bytes_sent = 0;
  logic [7:0]  byte_buf[$];
  logic        fin_buf[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  msgpack_stream_tokenizer uut (.*);

  mst_checker checker_i (.*);

  // receiver stall: random, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_cycles <= 300;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else
      out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run > 5000) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic put(input int b);
    byte_buf.push_back(8'(b)); fin_buf.push_back(1'b0);
  endtask

  task automatic put_n(input int n);
    repeat (n) put($urandom_range(255));
  endtask

  // send all queued bytes, marking the last of the buffer if asked
  task automatic flush(input logic end_buf);
    if (end_buf && fin_buf.size() > 0) fin_buf[fin_buf.size() - 1] = 1'b1;
    while (byte_buf.size() > 0) begin
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_valid <= 1'b1;
        data_byte <= byte_buf.pop_front();
        last_byte <= fin_buf.pop_front();
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // one random object with random content, nested at most a few levels
  task automatic gen_object(input int lvl);
    int sel, n;
    sel = $urandom_range(15);
    if (lvl > 3 && sel >= 13) sel = 0;
    case (sel)
      0: put($urandom_range(8'h7f));
      1: put($urandom_range(8'hff, 8'he0));
      2: put($urandom_range(8'hc3, 8'hc2));
      3: put(8'hc0);
      4: begin n = $urandom_range(8'hd3, 8'hca); put(n);
           put_n(n == 8'hcb || n == 8'hcf || n == 8'hd3 ? 8 :
                 (n == 8'hca || n == 8'hce || n == 8'hd2) ? 4 :
                 (n == 8'hcd || n == 8'hd1) ? 2 : 1); end
      5: begin n = $urandom_range(5); put(8'ha0 | n); put_n(n); end
      6: begin n = $urandom_range(4); put($urandom_range(8'hc4, 8'hc6)); // bin
           put(n); put_n(n); end
      7: begin n = $urandom_range(4); put(8'hd9); put(n); put_n(n); end
      8: begin put(8'hda); put(0); n = $urandom_range(3); put(n); put_n(n); end
      9: begin n = $urandom_range(8'hd8, 8'hd4); put(n);
           put($urandom_range(1) ? 8'hff : $urandom_range(255));
           put_n(1 << (n - 8'hd4)); end
      10: begin n = $urandom_range(12); put(8'hc7); put(n);
           put($urandom_range(1) ? 8'hff : $urandom_range(255)); put_n(n); end
      11: begin put(8'hdb); put(0); put(0); put(0); n = $urandom_range(2); put(n);
           put_n(n); end
      12: begin put(8'hc8); put(0); n = $urandom_range(3); put(n); put($urandom_range(255));
           put_n(n); end
      13: begin n = $urandom_range(3); put(8'h90 | n); repeat (n) gen_object(lvl + 1); end
      14: begin n = $urandom_range(2); put(8'h80 | n); repeat (2 * n) gen_object(lvl + 1); end
      default: begin n = $urandom_range(2);
           if ($urandom_range(1)) begin put(8'hdc); put(0); put(n); end
           else begin put(8'hde); put(0); put(n); n = 2 * n; end
           repeat (n) gen_object(lvl + 1); end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_tokens > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      case ($urandom_range(9))
        0: begin put_n($urandom_range(6)); flush($urandom_range(1)); end  // noise
        1: begin gen_object(0); if (byte_buf.size() > 1) void'(byte_buf.pop_back());
             flush(1); end                                                // cut short
        default: begin
          repeat ($urandom_range(1, 3)) gen_object(0);
          flush($urandom_range(3) == 0);
        end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: scalars, extremes, errors, timestamps and containers
    put(8'h00); put(8'h7f); put(8'he0); put(8'hff); put(8'hc0); put(8'hc2); put(8'hc3);
    put(8'hc1);
    put(8'hd3); put(8'h80); put_n(7);
    put(8'hcf); repeat (8) put(8'hff);
    put(8'hd0); put(8'h80); put(8'hd1); put(8'hff); put(8'hfe);
    put(8'hd6); put(8'hff); put_n(4);
    put(8'hd7); put(8'hff); repeat (8) put(8'hff);
    put(8'hc7); put(8'd12); put(8'hff); put_n(12);
    put(8'hc7); put(8'd0); put(8'h05);
    put(8'h90); put(8'h80); put(8'hdd); put(0); put(0); put(0); put(0);
    put(8'hdf); put(0); put(0); put(0); put(0);
    put(8'h92); put(8'h81); put(8'h01); put(8'ha1); put(8'h41); put(8'hcb); put_n(8);
    flush(1'b1);
    // nesting past the stack limit
    repeat (17) put(8'h91);
    put(8'h01);
    flush(1'b1);
    // truncation inside an open container and inside a length field
    put(8'h93); put(8'h01); flush(1'b1);
    put(8'hdb); put(8'hff); flush(1'b1);
    wait_drained();

    // random phases with changing idle mix
    send_idle_pct = 35; recv_idle_pct = 56;
    random_phase(130);
    // long receiver hold-off while the sender keeps offering
    hold_request++;
    random_phase(50);
    wait_drained();
    send_idle_pct = 56; recv_idle_pct = 35;
    random_phase(110);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(110);
    wait_drained();

    $display("sent %0d bytes; checked %0d tokens, %0d of them errors",
             bytes_sent, token_count, error_tokens);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mst_pkg.sv
rtl/core/mst_front.sv
rtl/core/mst_fifo.sv
rtl/core/mst_back.sv
rtl/core/msgpack_stream_tokenizer.sv
sim/mst_checker.sv
sim/tb.sv
